// ===== src/orlb_pkg.sv =====
// Shared types and constants for the overwrite ring log buffer.
`default_nettype none

package orlb_pkg;

  localparam int CntW = 6;
  localparam int WordW = 32;
  localparam logic [CntW-1:0] MAX_RUN = 6'd32;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_PEEK = 2'd1,
    KIND_POP  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [WordW-1:0] sample_data;
    logic [CntW-1:0]  max_items;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic             has_data;
    logic             last;
    logic [CntW-1:0]  returned_total;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic read_start;
    logic advance;
    logic cfg_write;
  } dp_cmd_t;

  typedef struct packed {
    logic final_entry;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/orlb_ctrl.sv =====
// Controller state machine that sequences pushes, read runs and configuration writes.
`default_nettype none

module orlb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [1:0]        req_kind,
  output logic                   req_stall,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  input  wire orlb_pkg::dp_stat_t stat,
  output orlb_pkg::dp_cmd_t      cmd
);

  orlb_pkg::state_t state;
  orlb_pkg::state_t state_next;
  logic             req_take;
  logic             is_read;

  assign req_take = (state == orlb_pkg::ST_IDLE) && req_valid && !cfg_valid;
  assign is_read  = (req_kind == orlb_pkg::KIND_PEEK) || (req_kind == orlb_pkg::KIND_POP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= orlb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      orlb_pkg::ST_IDLE: begin
        if (req_take && is_read) begin
          state_next = orlb_pkg::ST_RUN;
        end
      end
      orlb_pkg::ST_RUN: begin
        if (!rsp_stall && stat.final_entry) begin
          state_next = orlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = orlb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall      = 1'b1;
    cfg_ready      = 1'b0;
    rsp_valid      = 1'b0;
    cmd            = '0;
    case (state)
      orlb_pkg::ST_IDLE: begin
        cfg_ready      = 1'b1;
        req_stall      = cfg_valid;
        cmd.cfg_write  = cfg_valid;
        cmd.push       = req_take && (req_kind == orlb_pkg::KIND_PUSH);
        cmd.read_start = req_take && is_read;
      end
      orlb_pkg::ST_RUN: begin
        rsp_valid   = 1'b1;
        cmd.advance = !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/orlb_datapath.sv =====
// Datapath with the entry memory, ring pointers, fill count and result registers.
`default_nettype none

module orlb_datapath #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire orlb_pkg::dp_cmd_t           cmd,
  input  wire orlb_pkg::req_t              req,
  input  wire logic [orlb_pkg::CntW-1:0]   cfg_data,
  output orlb_pkg::dp_stat_t               stat,
  output orlb_pkg::rsp_t                   rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CapMax = (DEPTH > 63) ? 63 : DEPTH;
  localparam logic [orlb_pkg::CntW-1:0] CapMaxV = orlb_pkg::CntW'(CapMax);

  logic [DATA_WIDTH-1:0]     mem [DEPTH];
  logic [DATA_WIDTH-1:0]     rdata;
  logic [orlb_pkg::CntW-1:0] capacity;
  logic [orlb_pkg::CntW-1:0] wp;
  logic [orlb_pkg::CntW-1:0] fill;
  logic [orlb_pkg::CntW-1:0] rd_ptr;
  logic [orlb_pkg::CntW-1:0] rd_ptr_next;
  logic [orlb_pkg::CntW-1:0] remain;
  logic [orlb_pkg::CntW-1:0] total;
  logic                      has_data;
  logic [orlb_pkg::CntW-1:0] cap;
  logic [orlb_pkg::CntW:0]   wp_inc;
  logic [orlb_pkg::CntW:0]   rd_inc;
  logic [orlb_pkg::CntW-1:0] lim;
  logic [orlb_pkg::CntW-1:0] run_len;
  logic [orlb_pkg::CntW-1:0] back;
  logic [orlb_pkg::CntW:0]   start_raw;
  logic [orlb_pkg::CntW:0]   start_pos;
  logic                      is_pop;

  always_comb begin
    if (capacity == '0) begin
      cap = orlb_pkg::CntW'(1);
    end else if (capacity > CapMaxV) begin
      cap = CapMaxV;
    end else begin
      cap = capacity;
    end
  end

  assign is_pop  = (req.kind == orlb_pkg::KIND_POP);
  assign wp_inc  = {1'b0, wp} + 1'b1;
  assign rd_inc  = {1'b0, rd_ptr} + 1'b1;
  assign lim     = (fill < req.max_items) ? fill : req.max_items;
  assign run_len = (lim > orlb_pkg::MAX_RUN) ? orlb_pkg::MAX_RUN : lim;
  assign back    = is_pop ? run_len : fill;

  always_comb begin
    start_raw = {1'b0, wp} + {1'b0, cap} - {1'b0, back};
    if (start_raw >= {1'b0, cap}) begin
      start_pos = start_raw - {1'b0, cap};
    end else begin
      start_pos = start_raw;
    end
  end

  always_comb begin
    rd_ptr_next = rd_ptr;
    if (cmd.read_start) begin
      rd_ptr_next = start_pos[orlb_pkg::CntW-1:0];
    end else if (cmd.advance) begin
      rd_ptr_next = (rd_inc >= {1'b0, cap}) ? '0 : rd_inc[orlb_pkg::CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[AW'(wp)] <= DATA_WIDTH'(req.sample_data);
    end
    rdata <= mem[AW'(rd_ptr_next)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapMaxV;
      wp       <= '0;
      fill     <= '0;
      rd_ptr   <= '0;
      remain   <= '0;
      total    <= '0;
      has_data <= 1'b0;
    end else begin
      rd_ptr <= rd_ptr_next;
      if (cmd.cfg_write) begin
        capacity <= cfg_data;
        wp       <= '0;
        fill     <= '0;
      end else if (cmd.push) begin
        wp <= (wp_inc >= {1'b0, cap}) ? '0 : wp_inc[orlb_pkg::CntW-1:0];
        if (fill < cap) begin
          fill <= fill + 1'b1;
        end
      end else if (cmd.read_start) begin
        remain   <= run_len;
        total    <= run_len;
        has_data <= (run_len != '0);
        if (is_pop) begin
          fill <= '0;
        end
      end else if (cmd.advance && (remain != '0)) begin
        remain <= remain - 1'b1;
      end
    end
  end

  assign stat.final_entry   = (remain <= orlb_pkg::CntW'(1));
  assign rsp.read_data      = has_data ? orlb_pkg::WordW'(rdata) : '0;
  assign rsp.has_data       = has_data;
  assign rsp.last           = stat.final_entry;
  assign rsp.returned_total = total;

endmodule

`default_nettype wire

// ===== src/overwrite_ring_log_buffer.sv =====
// Top level of the overwrite ring log buffer: controller plus datapath.
`default_nettype none

// A push request gives no result, so pushes stream at one per clock while no
// configuration write is pending. A peek or pop request starts a run whose first result
// is offered in the cycle after the request is taken; the run is paced by rsp_stall and by
// the single registered read port of the entry memory. A read that returns nothing gives
// one empty result. While a run is being delivered, new requests and configuration writes
// are held off. The entry memory is not cleared after reset and needs no clearing pass.
module overwrite_ring_log_buffer #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire orlb_pkg::req_t            req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output orlb_pkg::rsp_t                 rsp,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [orlb_pkg::CntW-1:0] cfg_data
);

  orlb_pkg::dp_cmd_t  cmd;
  orlb_pkg::dp_stat_t stat;

  orlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  orlb_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_data (cfg_data),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ===== src/orlb_checker.sv =====
// Port-level checker for the overwrite ring log buffer and its bind statement.
`default_nettype none

module orlb_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire orlb_pkg::rsp_t rsp,
  input wire logic           cfg_ready
);

  // A stalled result must stay offered without change.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // An empty read gives a single zero result that closes its run.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_data |->
      rsp.last && (rsp.returned_total == '0) && (rsp.read_data == '0))
    else $error("malformed empty result");

  // A result with data reports a run length between one and the run limit.
  a_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_data |->
      (rsp.returned_total != '0) && (rsp.returned_total <= orlb_pkg::MAX_RUN))
    else $error("bad run length");

  // No request or configuration write is taken while a run is being delivered.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall && !cfg_ready)
    else $error("input taken during a run");

  // A taken result that is not the last one is followed by another of the same run.
  a_run: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp.last |=>
      rsp_valid && (rsp.returned_total == $past(rsp.returned_total)))
    else $error("run ended early");

endmodule

bind overwrite_ring_log_buffer orlb_checker u_orlb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== verif/overwrite_ring_log_buffer_tb.sv =====
// Self-checking testbench for the overwrite ring log buffer with a scoreboard class.
`default_nettype none

module overwrite_ring_log_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int DATA_WIDTH = 32;
  localparam int RESET_CYCLES = 7;
  localparam int CFG_SETTLE = 4;
  localparam int DRAIN_TAIL = 20;
  localparam int PHASE_ITEMS = 22;
  localparam int NUM_PHASES = 10;
  localparam int CYCLE_LIMIT = 2000000;

  class log_scoreboard;
    logic [orlb_pkg::WordW-1:0] ring_mem [DEPTH];
    logic [orlb_pkg::CntW-1:0] cap_reg;
    int wr_pos;
    int fill;
    int errors;
    int checked;
    orlb_pkg::rsp_t expected_q[$];

    function new();
      cap_reg = orlb_pkg::CntW'(DEPTH);
      wr_pos = 0;
      fill = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int ring_size();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return int'(cap_reg);
    endfunction

    function void note_config(logic [orlb_pkg::CntW-1:0] value);
      cap_reg = value;
      wr_pos = 0;
      fill = 0;
    endfunction

    function void note_request(orlb_pkg::req_t r);
      int cap;
      int n;
      int start;
      int i;
      orlb_pkg::rsp_t e;
      cap = ring_size();
      case (r.kind)
        orlb_pkg::KIND_PUSH: begin
          ring_mem[wr_pos] = r.sample_data;
          wr_pos = (wr_pos + 1 >= cap) ? 0 : wr_pos + 1;
          if (fill < cap) fill++;
        end
        orlb_pkg::KIND_PEEK, orlb_pkg::KIND_POP: begin
          n = fill;
          if (n > int'(r.max_items)) n = int'(r.max_items);
          if (n > int'(orlb_pkg::MAX_RUN)) n = int'(orlb_pkg::MAX_RUN);
          if (n == 0) begin
            e = '0;
            e.last = 1'b1;
            expected_q.push_back(e);
          end else begin
            // A peek starts at the oldest kept entry, a pop at the n-th newest one.
            start = (wr_pos + cap - ((r.kind == orlb_pkg::KIND_PEEK) ? fill : n)) % cap;
            for (i = 0; i < n; i++) begin
              e.read_data = ring_mem[(start + i) % cap];
              e.has_data = 1'b1;
              e.last = (i == n - 1);
              e.returned_total = orlb_pkg::CntW'(n);
              expected_q.push_back(e);
            end
          end
          if (r.kind == orlb_pkg::KIND_POP) fill = 0;
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [orlb_pkg::WordW-1:0] got,
                         logic [orlb_pkg::WordW-1:0] want);
      errors++;
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_response(orlb_pkg::rsp_t got);
      orlb_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unrequested result", got.read_data, '0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", got.read_data, want.read_data);
      if (got.has_data !== want.has_data)
        report_mismatch("has_data", orlb_pkg::WordW'(got.has_data),
                        orlb_pkg::WordW'(want.has_data));
      if (got.last !== want.last)
        report_mismatch("last", orlb_pkg::WordW'(got.last), orlb_pkg::WordW'(want.last));
      if (got.returned_total !== want.returned_total)
        report_mismatch("returned_total", orlb_pkg::WordW'(got.returned_total),
                        orlb_pkg::WordW'(want.returned_total));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  orlb_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  orlb_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [orlb_pkg::CntW-1:0] cfg_data = '0;

  logic calm = 1'b0;
  int stall_hold = 0;
  int stall_pick;
  int cycle_count = 0;
  int requests_sent = 0;
  int reads_sent = 0;
  int cfg_writes = 0;

  log_scoreboard sb = new();

  int phase_caps [NUM_PHASES] = '{2, 0, 32, 1, 63, 5, 33, 31, 17, 32};

  overwrite_ring_log_buffer #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(99);
      if (stall_pick < 60) begin
        rsp_stall <= 1'b0;
        stall_hold <= $urandom_range(12);
      end else if (stall_pick < 93) begin
        rsp_stall <= 1'b1;
        stall_hold <= $urandom_range(2);
      end else begin
        rsp_stall <= 1'b1;
        stall_hold <= $urandom_range(30, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(9, 4);
    return $urandom_range(35, 15);
  endfunction

  task automatic send_request(input orlb_pkg::kind_t kind,
                              input logic [orlb_pkg::WordW-1:0] data,
                              input logic [orlb_pkg::CntW-1:0] limit);
    orlb_pkg::req_t r;
    int gap;
    r.kind = kind;
    r.sample_data = data;
    r.max_items = limit;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    requests_sent++;
    if (kind == orlb_pkg::KIND_PEEK || kind == orlb_pkg::KIND_POP) reads_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [orlb_pkg::CntW-1:0] value);
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.note_config(value);
    cfg_writes++;
  endtask

  task automatic run_random_phase(input int quota, input bit fill_first);
    int sent;
    int burst;
    int p;
    orlb_pkg::kind_t read_kind;
    logic [orlb_pkg::CntW-1:0] limit;
    sent = 0;
    while (sent < quota) begin
      p = $urandom_range(99);
      if (p < 45) burst = $urandom_range(5, 1);
      else if (p < 80) burst = $urandom_range(20, 6);
      else burst = $urandom_range(45, 21);
      if ($urandom_range(99) < 10) burst = 0;
      if (fill_first) burst = 40;
      repeat (burst) begin
        send_request(orlb_pkg::KIND_PUSH, $urandom(), orlb_pkg::CntW'($urandom_range(63)));
        sent++;
      end
      if ($urandom_range(99) < 6)
        send_request(orlb_pkg::KIND_NONE, $urandom(), orlb_pkg::CntW'($urandom_range(63)));
      read_kind = $urandom_range(1) ? orlb_pkg::KIND_PEEK : orlb_pkg::KIND_POP;
      p = $urandom_range(99);
      if (p < 35) limit = orlb_pkg::CntW'($urandom_range(63));
      else if (p < 65) limit = orlb_pkg::CntW'($urandom_range(63, 32));
      else limit = orlb_pkg::CntW'($urandom_range(6));
      if (fill_first) limit = 6'd63;
      fill_first = 1'b0;
      send_request(read_kind, $urandom(), limit);
      sent++;
    end
  endtask

  initial begin
    int ph;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(orlb_pkg::KIND_PEEK, 32'h0, 6'd4);
    send_request(orlb_pkg::KIND_POP, 32'hffff_ffff, 6'd63);
    send_request(orlb_pkg::KIND_NONE, 32'h1234_5678, 6'd1);
    send_request(orlb_pkg::KIND_PUSH, 32'h0000_0000, 6'd0);
    send_request(orlb_pkg::KIND_PUSH, 32'hffff_ffff, 6'd63);
    send_request(orlb_pkg::KIND_PUSH, 32'haaaa_aaaa, 6'd21);
    send_request(orlb_pkg::KIND_PUSH, 32'h5555_5555, 6'd42);
    send_request(orlb_pkg::KIND_PEEK, 32'h0, 6'd0);
    send_request(orlb_pkg::KIND_PEEK, 32'h0, 6'd63);
    send_request(orlb_pkg::KIND_POP, 32'h0, 6'd1);
    send_request(orlb_pkg::KIND_PEEK, 32'h0, 6'd32);

    // A small ring: the oldest entries are overwritten before the reads.
    write_capacity(6'd3);
    repeat (5) send_request(orlb_pkg::KIND_PUSH, $urandom(), 6'd0);
    send_request(orlb_pkg::KIND_PEEK, 32'h0, 6'd63);
    send_request(orlb_pkg::KIND_POP, 32'h0, 6'd2);
    send_request(orlb_pkg::KIND_PUSH, $urandom(), 6'd0);
    send_request(orlb_pkg::KIND_PEEK, 32'h0, 6'd3);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(orlb_pkg::CntW'(phase_caps[ph]));
      calm <= (ph % 4 == 2);
      run_random_phase(PHASE_ITEMS, sb.ring_size() >= DEPTH);
    end

    req_valid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d requests (%0d reads) over %0d capacity settings.",
             requests_sent, reads_sent, cfg_writes + 1);
    $display("Compared %0d results against the predicted ring contents.", sb.checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
